// ===== rtl/mpts_pkg.sv =====
// ============================================================================
// mpts_pkg
// Shared types and constants of the multi-policy task scheduler: item
// structs, command and policy codes, controller/datapath command bundles.
// ============================================================================
package mpts_pkg;

    // input commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // scheduling policies
    localparam logic [2:0] MODE_FCFS    = 3'd0;
    localparam logic [2:0] MODE_SJF     = 3'd1;
    localparam logic [2:0] MODE_SRTF    = 3'd2;
    localparam logic [2:0] MODE_PRIO_NP = 3'd3;
    localparam logic [2:0] MODE_PRIO_P  = 3'd4;

    // configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_OBS    = 1'b1;

    localparam int OUT_TIME_W = 24;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = 28'hFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] duration;
        logic [7:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [3:0]            ran_slot;
        logic                  idle;
        logic                  finished;
        logic [OUT_TIME_W-1:0] turnaround;
        logic [OUT_TIME_W-1:0] waiting;
        logic                  in_window;
        logic [CNT_W-1:0]      completed_in_window;
        logic                  all_done;
        logic [OUT_TIME_W-1:0] current_time;
        logic [SUM_W-1:0]      sum_turnaround;
        logic [SUM_W-1:0]      sum_waiting;
    } t_out_item;

    // one entry of the task table
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] duration;
        logic [7:0]  priority_val;
        logic [15:0] remaining;
    } t_task_word;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic rst_clear;
        logic rst_rd;
        logic rst_wr;
        logic tick_start;
        logic scan_rd;
        logic time_inc;
        logic calc;
        logic acc;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic hold_ok;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/multi_policy_task_scheduler_core.sv =====
// ============================================================================
// multi_policy_task_scheduler_core
// Task scheduler with FCFS, SJF, SRTF and priority policies, one time unit
// per tick item, with completion statistics.
// ============================================================================
//
//  channel  dir  signals                                    item
//  -------  ---  -----------------------------------------  --------------------
//  in       in   i_in_valid  / o_in_ready  / i_in_item       load, tick, restart
//  out      out  o_out_valid / i_out_ready / o_out_item      one per tick
//  cfg      in   i_cfg_valid / o_cfg_ready / i_cfg_index,    policy, window
//                i_cfg_data
//
//  restart: a sweep rewinding remaining work, one read and one write of the
//  task table per slot.
//  tick: the scan is skipped when a held task keeps running; otherwise the
//  scan reads one task table entry per cycle.
//  reset is synchronous; the task table itself is not cleared, only the
//  loaded and done bits.
//  a tick holds in its last step while the previous result is not taken;
//  the cfg port is always ready.
//
module multi_policy_task_scheduler_core #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mpts_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mpts_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [mpts_pkg::OUT_TIME_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);

    mpts_pkg::t_dp_cmd  dp_cmd;
    mpts_pkg::t_dp_stat dp_stat;
    logic [SLOT_W-1:0]  scan_idx;

    mpts_ctrl #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_idx      (scan_idx)
    );

    mpts_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS),
        .SLOT_W     (SLOT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .i_idx       (scan_idx),
        .o_stat      (dp_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/mpts_ctrl.sv =====
// ============================================================================
// mpts_ctrl
// Sequencer of the scheduler: decodes accepted items and steps the datapath
// through load, restart sweep, slot scan and completion bookkeeping.
// ============================================================================
module mpts_ctrl #(
    parameter int TASK_SLOTS = 16,
    parameter int SLOT_W     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    output logic                o_in_ready,
    input  mpts_pkg::t_dp_stat  i_stat,
    output mpts_pkg::t_dp_cmd   o_cmd,
    output logic [SLOT_W-1:0]   o_idx
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_RST_RD = 4'd2;
    localparam logic [3:0] ST_RST_WR = 4'd3;
    localparam logic [3:0] ST_TICK   = 4'd4;
    localparam logic [3:0] ST_SCAN   = 4'd5;
    localparam logic [3:0] ST_PICK   = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_CALC   = 4'd8;
    localparam logic [3:0] ST_ACC    = 4'd9;
    localparam logic [3:0] ST_SUM    = 4'd10;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    logic [3:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_idx      = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_command)
                        mpts_pkg::CMD_LOAD:    n_state = ST_LOAD;
                        mpts_pkg::CMD_TICK:    n_state = ST_TICK;
                        mpts_pkg::CMD_RESTART: begin
                            n_state = ST_RST_RD;
                            n_idx   = '0;
                        end
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_RST_RD: begin
                o_cmd.rst_rd    = 1'b1;
                o_cmd.rst_clear = 1'b1;
                n_state         = ST_RST_WR;
            end
            ST_RST_WR: begin
                o_cmd.rst_wr = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = ST_RST_RD;
                end
            end
            ST_TICK: begin
                o_cmd.tick_start = 1'b1;
                n_idx            = '0;
                n_state          = i_stat.hold_ok ? ST_READ : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_PICK;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            // last compare of the scan lands here
            ST_PICK: n_state = ST_READ;
            ST_READ: begin
                o_cmd.time_inc = 1'b1;
                n_state        = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/mpts_dp.sv =====
// ============================================================================
// mpts_dp
// Datapath of the scheduler: task table memory, ready/key compare, pick and
// hold registers, time, completion statistics and the output register.
// ============================================================================
module mpts_dp #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 24,
    parameter int SLOT_W     = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpts_pkg::t_in_item                i_in_item,
    input  mpts_pkg::t_dp_cmd                 i_cmd,
    input  logic [SLOT_W-1:0]                 i_idx,
    output mpts_pkg::t_dp_stat                o_stat,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [mpts_pkg::OUT_TIME_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mpts_pkg::t_out_item               o_out_item
);

    localparam int CMP_W = (TIME_BITS > mpts_pkg::OUT_TIME_W) ? TIME_BITS
                                                              : mpts_pkg::OUT_TIME_W;
    localparam int ACC_W = ((TIME_BITS > mpts_pkg::SUM_W) ? TIME_BITS
                                                          : mpts_pkg::SUM_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // task table
    mpts_pkg::t_task_word r_mem [TASK_SLOTS];
    mpts_pkg::t_task_word r_rd_word;
    mpts_pkg::t_task_word wr_word;
    logic [SLOT_W-1:0]    rd_addr, wr_addr;
    logic                 wr_en;

    // control state
    logic [2:0]                      r_policy;
    logic [mpts_pkg::OUT_TIME_W-1:0] r_obs;
    logic [TIME_BITS-1:0]            r_time;
    logic [TASK_SLOTS-1:0]           r_loaded, r_done;
    logic [SLOT_W-1:0]               r_held;
    logic                            r_holding;
    logic [mpts_pkg::CNT_W-1:0]      r_wcount;
    logic [mpts_pkg::SUM_W-1:0]      r_sum_ta, r_sum_wt;
    logic                            r_found;
    logic                            r_cmp_en;
    logic                            r_out_vld;

    // payload
    mpts_pkg::t_in_item   r_item;
    mpts_pkg::t_out_item  r_out;
    logic [SLOT_W-1:0]    r_pick, r_cmp_slot;
    logic [15:0]          r_best;
    logic [15:0]          r_rem_new;
    logic                 r_fin;
    logic                 r_inwin;
    logic [TIME_BITS-1:0] r_ta, r_wt;

    logic                       slot_ok;
    logic [SLOT_W-1:0]          load_idx;
    logic [15:0]                load_dur;
    logic                       non_preempt;
    logic                       hold_ok;
    logic                       cand_ready;
    logic [15:0]                cand_key;
    logic [15:0]                rem_dec;
    logic [TIME_BITS-1:0]       arr_ext, dur_ext;
    logic [ACC_W-1:0]           sum_ta_raw, sum_wt_raw;
    logic [mpts_pkg::SUM_W-1:0] sum_ta_next, sum_wt_next;
    logic [mpts_pkg::CNT_W-1:0] wcount_next;
    logic                       out_free;

    assign slot_ok  = (32'(r_item.slot) < TASK_SLOTS);
    assign load_idx = SLOT_W'(r_item.slot);
    assign load_dur = (r_item.duration == 16'd0) ? 16'd1 : r_item.duration;

    assign non_preempt = (r_policy != mpts_pkg::MODE_SRTF) &&
                         (r_policy != mpts_pkg::MODE_PRIO_P);
    assign hold_ok     = non_preempt && r_holding && r_loaded[r_held] && !r_done[r_held];

    assign out_free        = !r_out_vld || i_out_ready;
    assign o_stat.hold_ok  = hold_ok;
    assign o_stat.out_free = out_free;
    assign o_cfg_ready     = 1'b1;

    assign arr_ext = TIME_BITS'(r_rd_word.arrival);
    assign dur_ext = TIME_BITS'(r_rd_word.duration);

    // candidate of the scan, one slot per cycle behind the read
    assign cand_ready = r_loaded[r_cmp_slot] && !r_done[r_cmp_slot] && (arr_ext <= r_time);

    always_comb begin
        case (r_policy)
            mpts_pkg::MODE_FCFS:    cand_key = r_rd_word.arrival;
            mpts_pkg::MODE_SJF:     cand_key = r_rd_word.duration;
            mpts_pkg::MODE_SRTF:    cand_key = r_rd_word.remaining;
            mpts_pkg::MODE_PRIO_NP: cand_key = 16'(r_rd_word.priority_val);
            mpts_pkg::MODE_PRIO_P:  cand_key = 16'(r_rd_word.priority_val);
            default:                cand_key = r_rd_word.arrival;
        endcase
    end

    assign rem_dec = (r_rd_word.remaining != 16'd0) ? r_rd_word.remaining - 16'd1 : 16'd0;

    // saturating totals
    assign sum_ta_raw  = ACC_W'(r_sum_ta) + ACC_W'(r_ta);
    assign sum_wt_raw  = ACC_W'(r_sum_wt) + ACC_W'(r_wt);
    assign sum_ta_next = !r_fin ? r_sum_ta :
                         (sum_ta_raw > ACC_W'(mpts_pkg::SUM_MAX)) ? mpts_pkg::SUM_MAX
                                                                  : mpts_pkg::SUM_W'(sum_ta_raw);
    assign sum_wt_next = !r_fin ? r_sum_wt :
                         (sum_wt_raw > ACC_W'(mpts_pkg::SUM_MAX)) ? mpts_pkg::SUM_MAX
                                                                  : mpts_pkg::SUM_W'(sum_wt_raw);
    assign wcount_next = (r_fin && r_inwin && (r_wcount != mpts_pkg::CNT_MAX))
                         ? r_wcount + mpts_pkg::CNT_W'(1) : r_wcount;

    // memory port selection
    assign rd_addr = (i_cmd.scan_rd || i_cmd.rst_rd) ? i_idx : r_pick;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pick;
        wr_word = r_rd_word;
        if (i_cmd.load_wr) begin
            wr_en                = slot_ok;
            wr_addr              = load_idx;
            wr_word.arrival      = r_item.arrival;
            wr_word.duration     = load_dur;
            wr_word.priority_val = r_item.priority_req;
            wr_word.remaining    = load_dur;
        end else if (i_cmd.rst_wr) begin
            wr_en             = 1'b1;
            wr_addr           = i_idx;
            wr_word.remaining = r_rd_word.duration;
        end else if (i_cmd.acc) begin
            wr_en             = r_found;
            wr_word.remaining = r_rem_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rd_word <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= mpts_pkg::MODE_FCFS;
            r_obs     <= '0;
            r_time    <= '0;
            r_loaded  <= '0;
            r_done    <= '0;
            r_held    <= '0;
            r_holding <= 1'b0;
            r_wcount  <= '0;
            r_sum_ta  <= '0;
            r_sum_wt  <= '0;
            r_found   <= 1'b0;
            r_cmp_en  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mpts_pkg::CFG_POLICY: r_policy <= i_cfg_data[2:0];
                    mpts_pkg::CFG_OBS:    r_obs    <= i_cfg_data;
                    default:              r_policy <= r_policy;
                endcase
            end

            r_cmp_en <= i_cmd.scan_rd;

            if (i_cmd.load_wr && slot_ok) begin
                r_loaded[load_idx] <= 1'b1;
                r_done[load_idx]   <= 1'b0;
                if (r_holding && (r_held == load_idx)) begin
                    r_holding <= 1'b0;
                end
            end

            if (i_cmd.rst_clear) begin
                r_time    <= '0;
                r_done    <= '0;
                r_held    <= '0;
                r_holding <= 1'b0;
                r_wcount  <= '0;
                r_sum_ta  <= '0;
                r_sum_wt  <= '0;
            end

            if (i_cmd.tick_start) begin
                r_found <= hold_ok;
            end else if (r_cmp_en && cand_ready && (!r_found || (cand_key < r_best))) begin
                r_found <= 1'b1;
            end

            if (i_cmd.time_inc && (r_time != TIME_MAX)) begin
                r_time <= r_time + TIME_BITS'(1);
            end

            if (i_cmd.acc && r_found) begin
                if (r_fin) begin
                    r_done[r_pick] <= 1'b1;
                    r_holding      <= 1'b0;
                end else begin
                    r_holding <= 1'b1;
                    r_held    <= r_pick;
                end
            end

            if (i_cmd.commit) begin
                r_wcount  <= wcount_next;
                r_sum_ta  <= sum_ta_next;
                r_sum_wt  <= sum_wt_next;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end

        r_cmp_slot <= i_idx;

        if (i_cmd.tick_start) begin
            r_pick <= r_held;
        end else if (r_cmp_en && cand_ready && (!r_found || (cand_key < r_best))) begin
            r_pick <= r_cmp_slot;
            r_best <= cand_key;
        end

        if (i_cmd.calc) begin
            r_rem_new <= rem_dec;
            r_fin     <= r_found && (rem_dec == 16'd0);
            // turnaround against the already advanced time
            if (r_found && (rem_dec == 16'd0) && (r_time >= arr_ext)) begin
                r_ta <= r_time - arr_ext;
            end else begin
                r_ta <= '0;
            end
        end

        if (i_cmd.acc) begin
            // waiting only counts on a completion, the table word is not used otherwise
            r_wt    <= (r_fin && (r_ta >= dur_ext)) ? r_ta - dur_ext : '0;
            r_inwin <= r_fin && (CMP_W'(r_time) <= CMP_W'(r_obs));
        end

        if (i_cmd.commit) begin
            r_out.ran_slot            <= r_found ? 4'(r_pick) : 4'd0;
            r_out.idle                <= !r_found;
            r_out.finished            <= r_fin;
            r_out.turnaround          <= mpts_pkg::OUT_TIME_W'(r_ta);
            r_out.waiting             <= mpts_pkg::OUT_TIME_W'(r_wt);
            r_out.in_window           <= r_inwin;
            r_out.completed_in_window <= wcount_next;
            r_out.all_done            <= ~|(r_loaded & ~r_done);
            r_out.current_time        <= mpts_pkg::OUT_TIME_W'(r_time);
            r_out.sum_turnaround      <= sum_ta_next;
            r_out.sum_waiting         <= sum_wt_next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // a finished slot is always a loaded one
    a_done_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done & ~r_loaded) == '0)
        else $error("done bit set on an unloaded slot");

    // a held task is never already finished
    a_hold_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holding |-> !r_done[r_held])
        else $error("hold points at a finished slot");

    // a completion only comes from a loaded, picked slot
    a_fin_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && r_fin) |-> (r_found && r_loaded[r_pick]))
        else $error("completion without a loaded pick");

    // a new result never overwrites one that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> out_free)
        else $error("result register overwritten");

    // time moves by exactly one per tick, unless saturated or cleared by a restart
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.time_inc) && !$past(i_cmd.rst_clear) && ($past(r_time) != TIME_MAX)
        |-> (r_time == $past(r_time) + TIME_BITS'(1)))
        else $error("time did not advance by one");

endmodule
